### rtl/triangle_raster_zbuffer_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triangle rasterizer
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_RASTER_ZBUFFER_UNIT_MACROS_SVH
`define TRIANGLE_RASTER_ZBUFFER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TRZB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TRZB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TRZB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define TRZB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/trzb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trzb_pkg
// Shared types and constants of the triangle rasterizer.
// ---------------------------------------------------------------------------
package trzb_pkg;

   localparam logic [1:0] OP_FILL  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic signed [15:0] DEPTH_ONE = 16'sd16384;

   localparam int EW = 36;   // edge function
   localparam int SW = 38;   // edge sum
   localparam int NW = 54;   // depth numerator
   localparam int MW = 19;   // multiplier operand
   localparam int PW = 38;   // multiplier product
   localparam int QW = 17;   // quotient magnitude bits

   localparam logic [4:0] MUL_LAST = 5'd17;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_PIX   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_RDMEM = 7'b0100000,
      ST_RDOUT = 7'b1000000
   } state_type;

endpackage

### rtl/triangle_raster_zbuffer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_raster_zbuffer_unit
// Fill: setup of the edge and depth terms on the shared multiplier, then a walk
// over the clipped box; each covered pixel runs the 17-step divider.
// Clear: every store entry is written, one store entry per cycle.
// Read: store read in ST_RDMEM; result register loaded in ST_RDOUT when not stalled.
// Reset: synchronous; a clearing pass over the whole store follows.
// ---------------------------------------------------------------------------
`include "triangle_raster_zbuffer_unit_macros.svh"
module triangle_raster_zbuffer_unit #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_ax,
   input  logic signed [15:0] req_ay,
   input  logic signed [15:0] req_az,
   input  logic signed [15:0] req_bx,
   input  logic signed [15:0] req_by,
   input  logic signed [15:0] req_bz,
   input  logic signed [15:0] req_cx,
   input  logic signed [15:0] req_cy,
   input  logic signed [15:0] req_cz,
   input  logic [23:0]        req_fill_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_read_color,
   output logic               rsp_out_of_range,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW    = trzb_pkg::EW;
   localparam int NW    = trzb_pkg::NW;
   localparam int SW    = trzb_pkg::SW;
   localparam int MW    = trzb_pkg::MW;
   localparam int PW    = trzb_pkg::PW;

   trzb_pkg::state_type state_ff, state_in;

   logic [6:0]          aw_ff, aw_in, ah_ff, ah_in, csr_v;
   logic signed [15:0]  ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff, cx_ff, cy_ff, cz_ff;
   logic signed [15:0]  ax_in, ay_in, az_in, bx_in, by_in, bz_in, cx_in, cy_in, cz_in;
   logic [23:0]         color_ff, color_in;
   logic [4:0]          mstep_ff, mstep_in;
   logic                phase_ff, phase_in;
   logic signed [EW-1:0] eab_ff, ebc_ff, eca_ff, eab_in, ebc_in, eca_in;
   logic signed [EW-1:0] rab_ff, rbc_ff, rca_ff, rab_in, rbc_in, rca_in;
   logic signed [EW-1:0] nsx_ff, nsy_ff, nsx_in, nsy_in;
   logic signed [NW-1:0] ncur_ff, nrow_ff, ncur_in, nrow_in;
   logic signed [SW-1:0] s_ff, s_in;
   logic [6:0]          x_ff, y_ff, x_in, y_in;
   logic [AW-1:0]       rbase_ff, rbase_in, clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_oor_ff, rsp_oor_in;
   logic [23:0]         rsp_color_ff, rsp_color_in;

   logic [23:0]         color_mem [DEPTH];
   logic signed [15:0]  depth_mem [DEPTH];
   logic [23:0]         color_rd_ff;
   logic signed [15:0]  depth_rd_ff;
   logic                mem_we;
   logic [AW-1:0]       waddr, rd_addr, pix_addr;
   logic [23:0]         wcolor;
   logic signed [15:0]  wdepth;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic                div_start, div_done;
   logic signed [15:0]  div_q;

   logic signed [16:0]  dabx, daby, dbcx, dbcy, dcax, dcay;
   logic signed [15:0]  minx, maxx, miny, maxy;
   logic signed [16:0]  x0s, x1s, y0s, y1s, limx, limy;
   logic signed [16:0]  oxa, oya, oxb, oyb, oxc, oyc;
   logic                box_empty, covered, rd_oor, accept, last_x;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != trzb_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign dabx = 17'(bx_ff) - 17'(ax_ff);
   assign daby = 17'(by_ff) - 17'(ay_ff);
   assign dbcx = 17'(cx_ff) - 17'(bx_ff);
   assign dbcy = 17'(cy_ff) - 17'(by_ff);
   assign dcax = 17'(ax_ff) - 17'(cx_ff);
   assign dcay = 17'(ay_ff) - 17'(cy_ff);

   always_comb begin
      minx = (ax_ff < bx_ff) ? ax_ff : bx_ff;
      minx = (minx < cx_ff) ? minx : cx_ff;
      maxx = (ax_ff > bx_ff) ? ax_ff : bx_ff;
      maxx = (maxx > cx_ff) ? maxx : cx_ff;
      miny = (ay_ff < by_ff) ? ay_ff : by_ff;
      miny = (miny < cy_ff) ? miny : cy_ff;
      maxy = (ay_ff > by_ff) ? ay_ff : by_ff;
      maxy = (maxy > cy_ff) ? maxy : cy_ff;
   end

   assign limx = $signed({10'b0, aw_ff}) - 17'sd1;
   assign limy = $signed({10'b0, ah_ff}) - 17'sd1;
   assign x0s  = (minx < 0) ? 17'sd0 : 17'(minx);
   assign y0s  = (miny < 0) ? 17'sd0 : 17'(miny);
   assign x1s  = (17'(maxx) > limx) ? limx : 17'(maxx);
   assign y1s  = (17'(maxy) > limy) ? limy : 17'(maxy);
   assign box_empty = (x0s > x1s) || (y0s > y1s);

   assign oxa = x0s - 17'(ax_ff);
   assign oya = y0s - 17'(ay_ff);
   assign oxb = x0s - 17'(bx_ff);
   assign oyb = y0s - 17'(by_ff);
   assign oxc = x0s - 17'(cx_ff);
   assign oyc = y0s - 17'(cy_ff);

   // operand schedule of the setup pass
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mstep_ff)
         5'd0:  begin mul_a = MW'(dabx);  mul_b = MW'(oya); end
         5'd1:  begin mul_a = MW'(daby);  mul_b = MW'(oxa); end
         5'd2:  begin mul_a = MW'(dbcx);  mul_b = MW'(oyb); end
         5'd3:  begin mul_a = MW'(dbcy);  mul_b = MW'(oxb); end
         5'd4:  begin mul_a = MW'(dcax);  mul_b = MW'(oyc); end
         5'd5:  begin mul_a = MW'(dcay);  mul_b = MW'(oxc); end
         5'd6:  begin mul_a = MW'(az_ff); mul_b = MW'(dbcy); end
         5'd7:  begin mul_a = MW'(bz_ff); mul_b = MW'(dcay); end
         5'd8:  begin mul_a = MW'(cz_ff); mul_b = MW'(daby); end
         5'd9:  begin mul_a = MW'(az_ff); mul_b = MW'(dbcx); end
         5'd10: begin mul_a = MW'(bz_ff); mul_b = MW'(dcax); end
         5'd11: begin mul_a = MW'(cz_ff); mul_b = MW'(dabx); end
         5'd12: begin mul_a = MW'(az_ff); mul_b = MW'($signed(ebc_ff[EW-1:18])); end
         5'd13: begin mul_a = MW'(az_ff); mul_b = $signed({1'b0, ebc_ff[17:0]}); end
         5'd14: begin mul_a = MW'(bz_ff); mul_b = MW'($signed(eca_ff[EW-1:18])); end
         5'd15: begin mul_a = MW'(bz_ff); mul_b = $signed({1'b0, eca_ff[17:0]}); end
         5'd16: begin mul_a = MW'(cz_ff); mul_b = MW'($signed(eab_ff[EW-1:18])); end
         5'd17: begin mul_a = MW'(cz_ff); mul_b = $signed({1'b0, eab_ff[17:0]}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   trzb_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   assign covered = (s_ff != 0) &&
                    ((eab_ff >= 0 && ebc_ff >= 0 && eca_ff >= 0) ||
                     (eab_ff <= 0 && ebc_ff <= 0 && eca_ff <= 0));
   assign div_start = (state_ff == trzb_pkg::ST_PIX) && covered;

   trzb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (ncur_ff),
      .den     (s_ff),
      .done_ff (div_done),
      .quot    (div_q)
   );

   assign rd_oor = (ax_ff < 0) || (ay_ff < 0) ||
                   (ax_ff >= $signed({9'b0, aw_ff})) || (ay_ff >= $signed({9'b0, ah_ff}));
   assign rd_addr  = AW'(14'(ay_ff[6:0]) * 14'(aw_ff) + 14'(ax_ff[6:0]));
   assign pix_addr = AW'(rbase_ff + AW'(x_ff));
   assign last_x   = (x_ff == x1s[6:0]);

   always_comb begin
      csr_v = (csr_data == 7'd0) ? 7'd1 : csr_data;
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (csr_valid) begin
         if (csr_index == 1'b0) begin
            aw_in = (32'(csr_v) > MAX_WIDTH) ? 7'(MAX_WIDTH) : csr_v;
         end else begin
            ah_in = (32'(csr_v) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : csr_v;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      color_in = color_ff;
      mstep_in = mstep_ff;
      phase_in = phase_ff;
      eab_in = eab_ff; ebc_in = ebc_ff; eca_in = eca_ff;
      rab_in = rab_ff; rbc_in = rbc_ff; rca_in = rca_ff;
      nsx_in = nsx_ff; nsy_in = nsy_ff;
      ncur_in = ncur_ff; nrow_in = nrow_ff;
      s_in = s_ff;
      x_in = x_ff; y_in = y_ff;
      rbase_in = rbase_ff;
      clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_color_in = rsp_color_ff;
      rsp_oor_in = rsp_oor_ff;
      mem_we = 1'b0;
      waddr  = clr_ff;
      wcolor = color_ff;
      wdepth = trzb_pkg::DEPTH_ONE;

      case (state_ff)
         trzb_pkg::ST_IDLE: begin
            if (accept) begin
               ax_in = req_ax; ay_in = req_ay; az_in = req_az;
               bx_in = req_bx; by_in = req_by; bz_in = req_bz;
               cx_in = req_cx; cy_in = req_cy; cz_in = req_cz;
               color_in = req_fill_color;
               mstep_in = 5'd0;
               phase_in = 1'b0;
               eab_in = '0; ebc_in = '0; eca_in = '0;
               nsx_in = '0; nsy_in = '0; ncur_in = '0;
               clr_in = '0;
               case (req_op)
                  trzb_pkg::OP_FILL:  state_in = trzb_pkg::ST_MUL;
                  trzb_pkg::OP_CLEAR: state_in = trzb_pkg::ST_CLEAR;
                  trzb_pkg::OP_READ:  state_in = trzb_pkg::ST_RDMEM;
                  default:            state_in = trzb_pkg::ST_IDLE;
               endcase
            end
         end
         trzb_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = AW'(clr_ff + AW'(1));
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = trzb_pkg::ST_IDLE;
            end
         end
         trzb_pkg::ST_MUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               case (mstep_ff)
                  5'd0:  eab_in = eab_ff + EW'(prod);
                  5'd1:  eab_in = eab_ff - EW'(prod);
                  5'd2:  ebc_in = ebc_ff + EW'(prod);
                  5'd3:  ebc_in = ebc_ff - EW'(prod);
                  5'd4:  eca_in = eca_ff + EW'(prod);
                  5'd5:  eca_in = eca_ff - EW'(prod);
                  5'd6, 5'd7, 5'd8:   nsx_in = nsx_ff - EW'(prod);
                  5'd9, 5'd10, 5'd11: nsy_in = nsy_ff + EW'(prod);
                  5'd12, 5'd14, 5'd16: ncur_in = ncur_ff + (NW'(prod) <<< 18);
                  5'd13, 5'd15, 5'd17: ncur_in = ncur_ff + NW'(prod);
                  default: ncur_in = ncur_ff;
               endcase
               if (mstep_ff == trzb_pkg::MUL_LAST) begin
                  if (box_empty) begin
                     state_in = trzb_pkg::ST_IDLE;
                  end else begin
                     state_in = trzb_pkg::ST_PIX;
                  end
                  rab_in = eab_ff; rbc_in = ebc_ff; rca_in = eca_ff;
                  nrow_in = ncur_in;
                  s_in = SW'(eab_ff) + SW'(ebc_ff) + SW'(eca_ff);
                  x_in = x0s[6:0];
                  y_in = y0s[6:0];
                  rbase_in = AW'(14'(y0s[6:0]) * 14'(aw_ff));
               end else begin
                  mstep_in = mstep_ff + 5'd1;
               end
            end
         end
         trzb_pkg::ST_PIX, trzb_pkg::ST_DIV: begin
            if (state_ff == trzb_pkg::ST_PIX && covered) begin
               state_in = trzb_pkg::ST_DIV;
            end else if (state_ff == trzb_pkg::ST_PIX || div_done) begin
               state_in = trzb_pkg::ST_PIX;
               if (state_ff == trzb_pkg::ST_DIV && div_q < depth_rd_ff) begin
                  mem_we = 1'b1;
                  waddr  = pix_addr;
                  wdepth = div_q;
               end
               if (!last_x) begin
                  x_in = x_ff + 7'd1;
                  eab_in = eab_ff - EW'(daby);
                  ebc_in = ebc_ff - EW'(dbcy);
                  eca_in = eca_ff - EW'(dcay);
                  ncur_in = ncur_ff + NW'(nsx_ff);
               end else if (y_ff == y1s[6:0]) begin
                  state_in = trzb_pkg::ST_IDLE;
               end else begin
                  x_in = x0s[6:0];
                  y_in = y_ff + 7'd1;
                  rbase_in = AW'(rbase_ff + AW'(aw_ff));
                  rab_in = rab_ff + EW'(dabx);
                  rbc_in = rbc_ff + EW'(dbcx);
                  rca_in = rca_ff + EW'(dcax);
                  eab_in = rab_in; ebc_in = rbc_in; eca_in = rca_in;
                  nrow_in = nrow_ff + NW'(nsy_ff);
                  ncur_in = nrow_in;
               end
            end
         end
         trzb_pkg::ST_RDMEM: begin
            state_in = trzb_pkg::ST_RDOUT;
         end
         trzb_pkg::ST_RDOUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_oor_in   = rd_oor;
               rsp_color_in = rd_oor ? 24'd0 : color_rd_ff;
               state_in     = trzb_pkg::ST_IDLE;
            end
         end
         default: state_in = trzb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trzb_pkg::ST_CLEAR;
         aw_ff        <= 7'(MAX_WIDTH);
         ah_ff        <= 7'(MAX_HEIGHT);
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         color_ff     <= '0;
         mstep_ff     <= '0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         color_ff     <= color_in;
         mstep_ff     <= mstep_in;
         phase_ff     <= phase_in;
      end
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      eab_ff <= eab_in; ebc_ff <= ebc_in; eca_ff <= eca_in;
      rab_ff <= rab_in; rbc_ff <= rbc_in; rca_ff <= rca_in;
      nsx_ff <= nsx_in; nsy_ff <= nsy_in;
      ncur_ff <= ncur_in; nrow_ff <= nrow_in;
      s_ff <= s_in;
      x_ff <= x_in; y_ff <= y_in;
      rbase_ff <= rbase_in;
      rsp_color_ff <= rsp_color_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem[waddr] <= wcolor;
         depth_mem[waddr] <= wdepth;
      end
      color_rd_ff <= color_mem[rd_addr];
      depth_rd_ff <= depth_mem[pix_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_color   = rsp_color_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   `TRZB_ASSERT_NOW(a_oor_black, clock, reset, rsp_valid && rsp_out_of_range, rsp_read_color == 24'd0, "out-of-range read returned a color")
   `TRZB_ASSERT_NEXT(a_busy_after_item, clock, reset, accept && req_op != trzb_pkg::OP_NONE, req_stall, "item taken but block not busy")
   `TRZB_ASSERT_NOW(a_write_state, clock, reset, mem_we, state_ff == trzb_pkg::ST_CLEAR || state_ff == trzb_pkg::ST_DIV, "store written outside clear or pixel update")

endmodule

### rtl/trzb_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trzb_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module trzb_mul (
   input  logic                                   clock,
   input  logic signed [trzb_pkg::MW-1:0]         op_a,
   input  logic signed [trzb_pkg::MW-1:0]         op_b,
   output logic signed [trzb_pkg::PW-1:0]         prod_ff
);

   logic signed [trzb_pkg::PW-1:0] prod_in;

   assign prod_in = trzb_pkg::PW'(op_a) * trzb_pkg::PW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/trzb_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trzb_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module trzb_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [trzb_pkg::NW-1:0]      num,
   input  logic signed [trzb_pkg::SW-1:0]      den,
   output logic                                done_ff,
   output logic signed [15:0]                  quot
);

   localparam int RW = trzb_pkg::NW + 1;

   logic                      busy_ff, busy_in, done_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [RW-1:0]             r_ff, r_in, d_ff, d_in;
   logic [trzb_pkg::QW-1:0]   q_ff, q_in;
   logic                      neg_ff, neg_in;
   logic signed [RW-1:0]      num_x, den_x, num_abs, den_abs;
   logic signed [trzb_pkg::QW:0] q_signed;
   logic                      ge;

   assign num_x   = RW'(num);
   assign den_x   = RW'(den);
   assign num_abs = (num_x < 0) ? -num_x : num_x;
   assign den_abs = (den_x < 0) ? -den_x : den_x;
   assign ge      = (r_ff >= d_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(trzb_pkg::QW - 1);
         r_in    = num_abs;
         d_in    = RW'(den_abs) << (trzb_pkg::QW - 1);
         q_in    = '0;
         neg_in  = num[trzb_pkg::NW-1] ^ den[trzb_pkg::SW-1];
      end else if (busy_ff) begin
         if (ge) begin
            r_in = r_ff - d_ff;
         end
         q_in = {q_ff[trzb_pkg::QW-2:0], ge};
         d_in = d_ff >> 1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   assign q_signed = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

   always_comb begin
      if (q_signed > 18'sd32767) begin
         quot = 16'sh7FFF;
      end else if (q_signed < -18'sd32768) begin
         quot = -16'sh8000;
      end else begin
         quot = 16'(q_signed);
      end
   end

endmodule

### dv/triangle_raster_zbuffer_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_raster_zbuffer_unit_test
// Self-checking bench for the triangle rasterizer. A scoreboard keeps its own
// color and depth image, rasterizes every accepted fill into it and predicts
// each read. Runs several screen sizes with random gaps on both channels.
// ---------------------------------------------------------------------------
module triangle_raster_zbuffer_unit_test;

   localparam int MAX_W = 64;
   localparam int MAX_H = 64;
   localparam int NPIX  = MAX_W * MAX_H;
   localparam bit REG_WIDTH  = 1'b0;
   localparam bit REG_HEIGHT = 1'b1;

   typedef struct {
      logic [1:0]         op;
      logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [23:0]        color;
   } raster_item_type;

   typedef struct {
      logic [23:0] color;
      logic        oor;
   } pixel_read_type;

   class pixel_scoreboard;
      logic [23:0]        color_mem [NPIX];
      logic signed [15:0] depth_mem [NPIX];
      int                 width, height;
      pixel_read_type     pending_reads [$];
      int                 errors;

      function void reset_state();
         width  = MAX_W;
         height = MAX_H;
         errors = 0;
         for (int i = 0; i < NPIX; i++) begin
            color_mem[i] = '0;
            depth_mem[i] = trzb_pkg::DEPTH_ONE;
         end
      endfunction

      function void write_reg(bit idx, logic [6:0] d);
         int v;
         v = int'(d);
         if (v < 1) v = 1;
         if (idx == REG_WIDTH) width = (v > MAX_W) ? MAX_W : v;
         else height = (v > MAX_H) ? MAX_H : v;
      endfunction

      function longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                               longint px, longint py);
         return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
      endfunction

      function void rasterize(raster_item_type it);
         int     x0, x1, y0, y1, idx;
         longint eab, ebc, eca, s, d;
         bit     pos, neg;
         x0 = it.ax; if (it.bx < x0) x0 = it.bx; if (it.cx < x0) x0 = it.cx;
         x1 = it.ax; if (it.bx > x1) x1 = it.bx; if (it.cx > x1) x1 = it.cx;
         y0 = it.ay; if (it.by < y0) y0 = it.by; if (it.cy < y0) y0 = it.cy;
         y1 = it.ay; if (it.by > y1) y1 = it.by; if (it.cy > y1) y1 = it.cy;
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x1 > width - 1) x1 = width - 1;
         if (y1 > height - 1) y1 = height - 1;
         for (int y = y0; y <= y1; y++) begin
            for (int x = x0; x <= x1; x++) begin
               eab = edge_fn(it.ax, it.ay, it.bx, it.by, x, y);
               ebc = edge_fn(it.bx, it.by, it.cx, it.cy, x, y);
               eca = edge_fn(it.cx, it.cy, it.ax, it.ay, x, y);
               s   = eab + ebc + eca;
               pos = eab >= 0 && ebc >= 0 && eca >= 0;
               neg = eab <= 0 && ebc <= 0 && eca <= 0;
               if (!(pos || neg) || s == 0) continue;
               d = (longint'(it.az) * ebc + longint'(it.bz) * eca
                    + longint'(it.cz) * eab) / s;
               if (d > 32767) d = 32767;
               if (d < -32768) d = -32768;
               idx = y * width + x;
               if (idx >= NPIX) continue;
               if (d < longint'(depth_mem[idx])) begin
                  depth_mem[idx] = 16'(d);
                  color_mem[idx] = it.color;
               end
            end
         end
      endfunction

      function void note_item(raster_item_type it);
         pixel_read_type r;
         int             x, y;
         case (it.op)
            trzb_pkg::OP_FILL: rasterize(it);
            trzb_pkg::OP_CLEAR: begin
               for (int i = 0; i < NPIX; i++) begin
                  color_mem[i] = it.color;
                  depth_mem[i] = trzb_pkg::DEPTH_ONE;
               end
            end
            trzb_pkg::OP_READ: begin
               x = it.ax;
               y = it.ay;
               if (x < 0 || y < 0 || x >= width || y >= height) begin
                  r.color = '0;
                  r.oor   = 1'b1;
               end else begin
                  r.color = color_mem[y * width + x];
                  r.oor   = 1'b0;
               end
               pending_reads = {pending_reads, r};
            end
            default: ;
         endcase
      endfunction

      function void check_read(logic [23:0] color, logic oor);
         pixel_read_type e;
         if (pending_reads.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: color=%06h oor=%0b", color, oor);
            return;
         end
         e = pending_reads.pop_front();
         if (color !== e.color || oor !== e.oor) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: color exp %06h got %06h, oor exp %0b got %0b",
                        e.color, color, e.oor, oor);
         end
      endfunction

      function int pending();
         return pending_reads.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic signed [15:0] req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   logic signed [15:0] req_cx, req_cy, req_cz;
   logic [23:0]        req_fill_color;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [23:0]        rsp_read_color;
   logic               rsp_out_of_range;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [6:0]         csr_data;

   pixel_scoreboard sb;
   bit              no_idle;
   bit              hold_req;

   triangle_raster_zbuffer_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("** triangle_raster_zbuffer_unit: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   task automatic send(raster_item_type it, int gap);
      req_op <= it.op;
      req_ax <= it.ax; req_ay <= it.ay; req_az <= it.az;
      req_bx <= it.bx; req_by <= it.by; req_bz <= it.bz;
      req_cx <= it.cx; req_cy <= it.cy; req_cz <= it.cz;
      req_fill_color <= it.color;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic raster_item_type make_item(logic [1:0] op, int ax, int ay, int az,
                                                 int bx, int by, int bz, int cx, int cy,
                                                 int cz, logic [23:0] color);
      raster_item_type it;
      it.op = op;
      it.ax = 16'(ax); it.ay = 16'(ay); it.az = 16'(az);
      it.bx = 16'(bx); it.by = 16'(by); it.bz = 16'(bz);
      it.cx = 16'(cx); it.cy = 16'(cy); it.cz = 16'(cz);
      it.color = color;
      return it;
   endfunction

   task automatic read_px(int x, int y);
      send(make_item(trzb_pkg::OP_READ, x, y, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 24'($urandom)), pick_gap());
   endtask

   // drain the block: a read behind everything in flight, then settle
   task automatic flush();
      send(make_item(trzb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'd0), 1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(bit idx, logic [6:0] d);
      csr_index <= idx;
      csr_data  <= d;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, d);
   endtask

   function automatic int rand_depth();
      if ($urandom_range(0, 3) == 0) return int'($urandom);
      return $urandom_range(0, 16384);
   endfunction

   task automatic random_item();
      int          r, cxp, cyp;
      logic [23:0] col;
      r   = $urandom_range(0, 99);
      col = 24'($urandom);
      if (r < 45) begin
         if (sb.width * sb.height <= 256 && $urandom_range(0, 3) == 0)
            send(make_item(trzb_pkg::OP_FILL, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom, col),
                 pick_gap());
         else begin
            cxp = $urandom_range(0, sb.width - 1);
            cyp = $urandom_range(0, sb.height - 1);
            send(make_item(trzb_pkg::OP_FILL,
                           cxp + $urandom_range(0, 8) - 4, cyp + $urandom_range(0, 8) - 4,
                           rand_depth(),
                           cxp + $urandom_range(0, 8) - 4, cyp + $urandom_range(0, 8) - 4,
                           rand_depth(),
                           cxp + $urandom_range(0, 8) - 4, cyp + $urandom_range(0, 8) - 4,
                           rand_depth(), col), pick_gap());
         end
      end else if (r < 92) begin
         if ($urandom_range(0, 4) == 0) read_px($urandom, $urandom);
         else read_px($urandom_range(0, sb.width - 1), $urandom_range(0, sb.height - 1));
      end else if (r < 94) begin
         send(make_item(trzb_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, col),
              pick_gap());
      end else if (r < 97) begin
         send(make_item(trzb_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, col),
              pick_gap());
      end else begin
         // extreme depths on a small triangle
         cxp = $urandom_range(0, sb.width - 1);
         cyp = $urandom_range(0, sb.height - 1);
         send(make_item(trzb_pkg::OP_FILL, cxp - 2, cyp - 2, -32768, cxp + 3, cyp, 32767,
                        cxp, cyp + 3, $urandom, col), pick_gap());
      end
   endtask

   // result side
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            n = 3000;
         end else n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check_read(rsp_read_color, rsp_out_of_range);
      end
   end

   initial begin
      int pw [8];
      int ph [8];
      pw = '{64, 0, 127, 8, 1, 37, 16, 64};
      ph = '{64, 127, 0, 8, 1, 23, 16, 64};
      sb = new();
      sb.reset_state();
      reset = 1'b1;
      req_valid = 1'b0; req_op = trzb_pkg::OP_NONE;
      req_ax = '0; req_ay = '0; req_az = '0; req_bx = '0; req_by = '0; req_bz = '0;
      req_cx = '0; req_cy = '0; req_cz = '0; req_fill_color = '0;
      csr_valid = 1'b0; csr_index = 1'b0; csr_data = '0;
      no_idle = 1'b0; hold_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      read_px(0, 0);
      read_px(63, 63);
      read_px(-1, 0);
      read_px(64, 0);
      read_px(0, 64);
      read_px(-32768, 32767);
      send(make_item(trzb_pkg::OP_FILL, -32768, -32768, 8192, 32767, -32768, 8192,
                     -32768, 32767, 8192, 24'hFF0000), pick_gap());
      read_px(0, 0);
      read_px(63, 63);
      send(make_item(trzb_pkg::OP_FILL, 5, 5, 0, 15, 5, 0, 5, 15, 0, 24'h00FF00), 0);
      send(make_item(trzb_pkg::OP_FILL, 5, 5, 0, 5, 15, 0, 15, 5, 0, 24'h0000FF), 0);
      read_px(6, 6);
      send(make_item(trzb_pkg::OP_FILL, 20, 20, -32768, 30, 20, -32768, 20, 30, -32768,
                     24'h123456), 0);
      read_px(21, 21);
      send(make_item(trzb_pkg::OP_FILL, 1, 1, 0, 5, 5, 0, 9, 9, 0, 24'hABCDEF), 0);
      read_px(5, 5);
      send(make_item(trzb_pkg::OP_FILL, -30, -30, 0, -10, -30, 0, -30, -10, 0,
                     24'h777777), 0);
      send(make_item(trzb_pkg::OP_NONE, 5, 5, 0, 9, 5, 0, 5, 9, 0, 24'h555555), 0);
      read_px(6, 6);
      send(make_item(trzb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF), 0);
      read_px(63, 0);
      send(make_item(trzb_pkg::OP_FILL, 40, 40, 32767, 50, 40, 32767, 40, 50, 16383,
                     24'h00000F), 0);
      read_px(41, 41);
      flush();

      for (int p = 0; p < 8; p++) begin
         if (p == 7) begin
            write_reg(REG_WIDTH, 7'($urandom));
            write_reg(REG_HEIGHT, 7'($urandom));
         end else begin
            write_reg(REG_WIDTH, 7'(pw[p]));
            write_reg(REG_HEIGHT, 7'(ph[p]));
         end
         no_idle = (p == 5);
         for (int i = 0; i < 190; i++) begin
            if (p == 3 && i == 60) hold_req = 1'b1;
            if (p == 3 && i >= 60 && i < 80) read_px($urandom_range(0, 7),
                                                     $urandom_range(0, 7));
            else random_item();
         end
         flush();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("** triangle_raster_zbuffer_unit: PASSED **");
      else
         $display("** triangle_raster_zbuffer_unit: FAILED **");
      $finish;
   end

endmodule
